// ===== src/qes_pkg.sv =====
// Shared types, widths and helpers for the quadratic equation solver.
`default_nettype none
package qes_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_W        = 32;
  localparam int TOL_W         = 16;
  // exact discriminant b*b - 4*a*c, signed
  localparam int DISC_W        = 2 * COEF_W + 2;
  // bits of the integer square root of the discriminant
  localparam int SQRT_W        = DISC_W / 2;
  // base numerator (-b or -c) and signed denominator (2a or b)
  localparam int NUM_W         = COEF_W + 1;
  localparam int DEN_W         = COEF_W + 2;
  // signed numerator -b +/- sqrt(D), and its magnitude
  localparam int NSUM_W        = COEF_W + 3;
  localparam int NMAG_W        = COEF_W + 2;
  // denominator magnitude
  localparam int DMAG_W        = COEF_W + 1;

  typedef enum logic [1:0] {
    ROOTS_NONE = 2'd0,
    ROOTS_ONE  = 2'd1,
    ROOTS_TWO  = 2'd2,
    ROOTS_INF  = 2'd3
  } count_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic [1:0]               root_count;
    logic signed [COEF_W-1:0] root_low;
    logic signed [COEF_W-1:0] root_high;
    logic                     overflow;
  } result_t;

  // magnitude of a coefficient, one bit wider so the most negative value fits
  function automatic logic [COEF_W:0] coef_mag(input logic signed [COEF_W-1:0] v);
    logic signed [COEF_W:0] w;
    w = {v[COEF_W-1], v};
    return v[COEF_W-1] ? -w : w;
  endfunction

endpackage
`default_nettype wire

// ===== src/quadratic_equation_solver.sv =====
// Top level of the fixed-point quadratic equation solver (real roots).
// The solver takes one coefficient transaction per clock while in_ready is high
// and returns one result transaction per input, in order. Roots are Q16.16 at
// the default FRAC_BITS. Four front stages form b*b, a*c, the exact discriminant
// and the case, a chain of 33 square-root cells resolves one root bit each, two
// setup stages form the numerators, two parallel chains of 34 + FRAC_BITS
// divider cells resolve one quotient bit each, and two stages saturate, zero-snap
// and sort the roots ahead of the output register. A skid register behind the
// output lets the pipeline run until it holds a result; in_ready drops only while
// that skid register is full. zero_tolerance may be written only while no
// transaction is in flight.
`default_nettype none
module quadratic_equation_solver #(
  parameter int FRAC_BITS = qes_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [qes_pkg::TOL_W-1:0]  cfg_zero_tolerance,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  qes_pkg::coef_t             in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qes_pkg::result_t           out_data
);
  import qes_pkg::*;

  localparam int QUO_W = NMAG_W + FRAC_BITS;
  localparam logic [QUO_W-1:0] POS_LIM = QUO_W'({(COEF_W-1){1'b1}});
  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'({1'b1, {(COEF_W-1){1'b0}}});

  logic en, acc, push;
  logic [TOL_W-1:0] tol_r;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid) begin
      tol_r <= cfg_zero_tolerance;
    end
  end

  logic skid_valid_r, out_valid_r;
  result_t skid_r, out_data_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign acc      = in_valid && in_ready;

  // stage 0: capture the transaction
  logic  s0_valid_r;
  coef_t s0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= acc;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_data;
    end
  end

  // stage 1: products b*b and a*c
  logic s1_valid_r;
  logic signed [2*COEF_W-1:0] s1_bb_r, s1_ac_r, bb_full, ac_full;
  logic signed [COEF_W-1:0]   s1_a_r, s1_b_r, s1_c_r;
  assign bb_full = $signed(s0_r.coef_b) * $signed(s0_r.coef_b);
  assign ac_full = $signed(s0_r.coef_a) * $signed(s0_r.coef_c);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_bb_r <= bb_full;
      s1_ac_r <= ac_full;
      s1_a_r  <= s0_r.coef_a;
      s1_b_r  <= s0_r.coef_b;
      s1_c_r  <= s0_r.coef_c;
    end
  end

  // stage 2: exact discriminant and near-zero flags of the coefficients
  logic s2_valid_r, s2_az_r, s2_bz_r, s2_cz_r;
  logic signed [DISC_W-1:0] s2_d_r, d_full;
  logic signed [COEF_W-1:0] s2_a_r, s2_b_r, s2_c_r;
  assign d_full = DISC_W'(s1_bb_r) - (DISC_W'(s1_ac_r) <<< 2);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_d_r  <= d_full;
      s2_az_r <= coef_mag(s1_a_r) <= (COEF_W+1)'(tol_r);
      s2_bz_r <= coef_mag(s1_b_r) <= (COEF_W+1)'(tol_r);
      s2_cz_r <= coef_mag(s1_c_r) <= (COEF_W+1)'(tol_r);
      s2_a_r  <= s1_a_r;
      s2_b_r  <= s1_b_r;
      s2_c_r  <= s1_c_r;
    end
  end

  // stage 3: pick the case, base numerator, denominator and radicand
  logic s3_valid_r;
  count_t s3_kind_r, kind3;
  logic signed [NUM_W-1:0] s3_nb_r, nb3;
  logic signed [DEN_W-1:0] s3_den_r, den3;
  logic [DISC_W-1:0] s3_rad_r, rad3, dmag, dlim;
  logic dz;
  always_comb begin
    dmag  = s2_d_r[DISC_W-1] ? -s2_d_r : s2_d_r;
    dlim  = DISC_W'(tol_r) << FRAC_BITS;
    dz    = (dmag <= dlim);
    kind3 = ROOTS_NONE;
    nb3   = -NUM_W'(s2_b_r);
    den3  = DEN_W'(s2_a_r) <<< 1;
    rad3  = '0;
    if (s2_az_r) begin
      if (s2_bz_r) begin
        kind3 = s2_cz_r ? ROOTS_INF : ROOTS_NONE;
      end else begin
        kind3 = ROOTS_ONE;
        nb3   = -NUM_W'(s2_c_r);
        den3  = DEN_W'(s2_b_r);
      end
    end else if (dz) begin
      kind3 = ROOTS_ONE;
    end else if (!s2_d_r[DISC_W-1]) begin
      kind3 = ROOTS_TWO;
      rad3  = s2_d_r;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_kind_r <= kind3;
      s3_nb_r   <= nb3;
      s3_den_r  <= den3;
      s3_rad_r  <= rad3;
    end
  end

  // square-root chain, one root bit per cell
  logic [DISC_W-1:0] sq_rad  [SQRT_W+1];
  logic [SQRT_W+1:0] sq_rem  [SQRT_W+1];
  logic [SQRT_W-1:0] sq_root [SQRT_W+1];
  logic [SQRT_W-1:0] sq_valid_r;
  count_t                  sq_kind_r [SQRT_W];
  logic signed [NUM_W-1:0] sq_nb_r   [SQRT_W];
  logic signed [DEN_W-1:0] sq_den_r  [SQRT_W];

  assign sq_rad[0]  = s3_rad_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQRT_W; i++) begin : g_sqrt
    qes_sqrt_cell #(.N(SQRT_W)) u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // carry case and operands alongside the root cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= '0;
    end else if (en) begin
      sq_valid_r <= {sq_valid_r[SQRT_W-2:0], s3_valid_r};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_kind_r[0] <= s3_kind_r;
      sq_nb_r[0]   <= s3_nb_r;
      sq_den_r[0]  <= s3_den_r;
      for (int k = 1; k < SQRT_W; k++) begin
        sq_kind_r[k] <= sq_kind_r[k-1];
        sq_nb_r[k]   <= sq_nb_r[k-1];
        sq_den_r[k]  <= sq_den_r[k-1];
      end
    end
  end

  // stage 4: numerators -b - s and -b + s
  logic s4_valid_r;
  count_t s4_kind_r;
  logic signed [NSUM_W-1:0] s4_n_r [2];
  logic signed [NSUM_W-1:0] nb_x, s_x;
  logic signed [DEN_W-1:0]  s4_den_r;
  always_comb begin
    nb_x = NSUM_W'(sq_nb_r[SQRT_W-1]);
    s_x  = (sq_kind_r[SQRT_W-1] == ROOTS_TWO) ? $signed(NSUM_W'(sq_root[SQRT_W])) : '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= sq_valid_r[SQRT_W-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_kind_r <= sq_kind_r[SQRT_W-1];
      s4_den_r  <= sq_den_r[SQRT_W-1];
      s4_n_r[0] <= nb_x - s_x;
      s4_n_r[1] <= nb_x + s_x;
    end
  end

  // stage 5: magnitudes and quotient signs
  logic s5_valid_r;
  count_t s5_kind_r;
  logic [NMAG_W-1:0] s5_nmag_r [2];
  logic [DMAG_W-1:0] s5_den_r;
  logic [1:0]        s5_neg_r;
  logic              dneg;
  assign dneg = s4_den_r[DEN_W-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_kind_r <= s4_kind_r;
      s5_den_r  <= DMAG_W'(dneg ? -s4_den_r : s4_den_r);
      for (int l = 0; l < 2; l++) begin
        s5_nmag_r[l] <= NMAG_W'(s4_n_r[l][NSUM_W-1] ? -s4_n_r[l] : s4_n_r[l]);
        s5_neg_r[l]  <= s4_n_r[l][NSUM_W-1] ^ dneg;
      end
    end
  end

  // divider chains, one per root, one quotient bit per cell
  logic [DMAG_W-1:0] dv_den [2][QUO_W+1];
  logic [DMAG_W-1:0] dv_rem [2][QUO_W+1];
  logic [QUO_W-1:0]  dv_nq  [2][QUO_W+1];
  logic [QUO_W-1:0]  dv_valid_r;
  count_t            dv_kind_r [QUO_W];
  logic [1:0]        dv_neg_r  [QUO_W];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign dv_den[l][0] = s5_den_r;
    assign dv_rem[l][0] = '0;
    assign dv_nq[l][0]  = {s5_nmag_r[l], {FRAC_BITS{1'b0}}};
    for (genvar i = 0; i < QUO_W; i++) begin : g_div
      qes_div_cell #(.DW(DMAG_W), .QW(QUO_W)) u_cell (
        .clk   (clk),
        .en    (en),
        .den_i (dv_den[l][i]),
        .rem_i (dv_rem[l][i]),
        .nq_i  (dv_nq[l][i]),
        .den_o (dv_den[l][i+1]),
        .rem_o (dv_rem[l][i+1]),
        .nq_o  (dv_nq[l][i+1])
      );
    end
  end

  // carry case and signs alongside the divider cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r <= '0;
    end else if (en) begin
      dv_valid_r <= {dv_valid_r[QUO_W-2:0], s5_valid_r};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_kind_r[0] <= s5_kind_r;
      dv_neg_r[0]  <= s5_neg_r;
      for (int k = 1; k < QUO_W; k++) begin
        dv_kind_r[k] <= dv_kind_r[k-1];
        dv_neg_r[k]  <= dv_neg_r[k-1];
      end
    end
  end

  // stage 6: apply sign, saturate and snap near-zero roots
  logic s6_valid_r;
  count_t s6_kind_r;
  logic signed [COEF_W-1:0] s6_x_r [2];
  logic signed [COEF_W-1:0] x6 [2];
  logic [1:0] s6_sat_r, sat6;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dv_neg_r[QUO_W-1][l]) begin
        sat6[l] = dv_nq[l][QUO_W] > NEG_LIM;
        x6[l]   = sat6[l] ? $signed({1'b1, {(COEF_W-1){1'b0}}})
                          : -$signed(dv_nq[l][QUO_W][COEF_W-1:0]);
      end else begin
        sat6[l] = dv_nq[l][QUO_W] > POS_LIM;
        x6[l]   = sat6[l] ? $signed({1'b0, {(COEF_W-1){1'b1}}})
                          : $signed(dv_nq[l][QUO_W][COEF_W-1:0]);
      end
      if (!sat6[l] && (dv_nq[l][QUO_W] <= QUO_W'(tol_r))) begin
        x6[l] = '0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r <= dv_valid_r[QUO_W-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_kind_r <= dv_kind_r[QUO_W-1];
      s6_sat_r  <= sat6;
      s6_x_r[0] <= x6[0];
      s6_x_r[1] <= x6[1];
    end
  end

  // stage 7: sort and assemble the result
  logic s7_valid_r;
  result_t s7_r, res7;
  always_comb begin
    res7            = '0;
    res7.root_count = s6_kind_r;
    unique case (s6_kind_r)
      ROOTS_ONE: begin
        res7.root_low  = s6_x_r[0];
        res7.root_high = s6_x_r[0];
        res7.overflow  = s6_sat_r[0];
      end
      ROOTS_TWO: begin
        res7.root_low  = (s6_x_r[0] <= s6_x_r[1]) ? s6_x_r[0] : s6_x_r[1];
        res7.root_high = (s6_x_r[0] <= s6_x_r[1]) ? s6_x_r[1] : s6_x_r[0];
        res7.overflow  = |s6_sat_r;
      end
      default: begin
        res7.root_low  = '0;
        res7.root_high = '0;
        res7.overflow  = 1'b0;
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (en) begin
      s7_valid_r <= s6_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_r <= res7;
    end
  end

  // output register with skid: hold on stall, park the next result in the skid
  assign push = en && s7_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (push) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= push;
    end
  end
  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (push) begin
        skid_r <= s7_r;
      end
    end else if (skid_valid_r) begin
      out_data_r <= skid_r;
    end else if (push) begin
      out_data_r <= s7_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a parked result always sits behind a shown one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  // the skid fills only from a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled without an output stall");

  // two roots come out in ascending order
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.root_count == ROOTS_TWO) |->
      ($signed(out_data_r.root_low) <= $signed(out_data_r.root_high)))
    else $error("two roots out of order");

  // no root or infinitely many roots report zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.root_count == ROOTS_NONE ||
                     out_data_r.root_count == ROOTS_INF)) |->
      (out_data_r.root_low == '0 && out_data_r.root_high == '0 && !out_data_r.overflow))
    else $error("nonzero roots reported without a finite root set");

  // a single root is reported twice
  a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.root_count == ROOTS_ONE) |->
      (out_data_r.root_low == out_data_r.root_high))
    else $error("single root differs between low and high");

endmodule
`default_nettype wire

// ===== src/qes_sqrt_cell.sv =====
// One cell of the pipelined integer square root: resolves one root bit.
`default_nettype none
module qes_sqrt_cell #(
  parameter int N = qes_pkg::SQRT_W
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] rad_i,
  input  logic [N+1:0]   rem_i,
  input  logic [N-1:0]   root_i,
  output logic [2*N-1:0] rad_o,
  output logic [N+1:0]   rem_o,
  output logic [N-1:0]   root_o
);
  import qes_pkg::*;

  logic [2*N-1:0] rad_r;
  logic [N+1:0]   rem_r, rem_nxt;
  logic [N-1:0]   root_r, root_nxt;
  logic [N+3:0]   rem_sh, trial, diff;
  logic           take;

  // bring down the next two radicand bits and try root*4+1
  always_comb begin
    rem_sh   = {rem_i, rad_i[2*N-1 -: 2]};
    trial    = (N+4)'({root_i, 2'b01});
    diff     = rem_sh - trial;
    take     = (rem_sh >= trial);
    rem_nxt  = take ? diff[N+1:0] : rem_sh[N+1:0];
    root_nxt = {root_i[N-2:0], take};
  end

  // advance with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[2*N-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

// ===== src/qes_div_cell.sv =====
// One cell of the pipelined restoring divider: resolves one quotient bit.
`default_nettype none
module qes_div_cell #(
  parameter int DW = qes_pkg::DMAG_W,
  parameter int QW = qes_pkg::NMAG_W + qes_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] nq_i,
  output logic [DW-1:0] den_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] nq_o
);
  import qes_pkg::*;

  logic [DW-1:0] den_r, rem_r, rem_nxt;
  logic [QW-1:0] nq_r;
  logic [DW:0]   part, diff;
  logic          take;

  // shift in the next numerator bit and subtract the divisor if it fits
  always_comb begin
    part    = {rem_i, nq_i[QW-1]};
    diff    = part - {1'b0, den_i};
    take    = (part >= {1'b0, den_i});
    rem_nxt = take ? diff[DW-1:0] : part[DW-1:0];
  end

  // advance with the pipeline; quotient bits fill from the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      rem_r <= rem_nxt;
      nq_r  <= {nq_i[QW-2:0], take};
    end
  end

  assign den_o = den_r;
  assign rem_o = rem_r;
  assign nq_o  = nq_r;

endmodule
`default_nettype wire

// ===== sim/tb_quadratic_equation_solver.sv =====
// Self-checking testbench for the fixed-point quadratic equation solver.
`default_nettype none
module tb_quadratic_equation_solver;
  import qes_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 76 + FB;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_zero_tolerance = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  coef_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;

  // predictor copy of the register
  logic [TOL_W-1:0] tol_q = '0;
  result_t roots_expected[$];
  int err_count = 0;
  longint cycle_count = 0;
  bit rx_idle_enable = 1'b0;
  bit tx_idle_enable = 1'b0;
  int hold_off_cycles = 0;

  quadratic_equation_solver dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_zero_tolerance(cfg_zero_tolerance),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic bit is_near_zero(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = v < 0 ? -v : v;
    return m <= $signed({112'd0, tol_q});
  endfunction

  function automatic logic signed [31:0] root_of(input logic signed [127:0] num,
                                                 input logic signed [127:0] den,
                                                 inout bit ovf);
    logic signed [127:0] q;
    q = (num <<< FB) / den;
    if (q > 128'sd2147483647) begin
      q = 128'sd2147483647;
      ovf = 1'b1;
    end else if (q < -128'sd2147483648) begin
      q = -128'sd2147483648;
      ovf = 1'b1;
    end
    if (is_near_zero(q)) q = 0;
    return q[31:0];
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] n);
    logic [127:0] r;
    r = 0;
    for (int i = 63; i >= 0; i--)
      if ((r | (128'd1 << i)) * (r | (128'd1 << i)) <= n) r = r | (128'd1 << i);
    return r;
  endfunction

  function automatic result_t solve_roots(input coef_t c);
    result_t r;
    logic signed [127:0] a, b, k, d, s, lim;
    logic signed [31:0] x1, x2;
    bit ovf;
    a = c.coef_a; b = c.coef_b; k = c.coef_c;
    ovf = 1'b0;
    r = '0;
    if (is_near_zero(a)) begin
      if (is_near_zero(b)) begin
        r.root_count = is_near_zero(k) ? ROOTS_INF : ROOTS_NONE;
      end else begin
        r.root_low = root_of(-k, b, ovf);
        r.root_high = r.root_low;
        r.root_count = ROOTS_ONE;
      end
    end else begin
      d = b * b - 4 * a * k;
      lim = $signed({112'd0, tol_q}) <<< FB;
      if ((d < 0 ? -d : d) <= lim) begin
        r.root_low = root_of(-b, 2 * a, ovf);
        r.root_high = r.root_low;
        r.root_count = ROOTS_ONE;
      end else if (d > 0) begin
        s = int_sqrt(d);
        x1 = root_of(-b - s, 2 * a, ovf);
        x2 = root_of(-b + s, 2 * a, ovf);
        r.root_low = (x1 <= x2) ? x1 : x2;
        r.root_high = (x1 <= x2) ? x2 : x1;
        r.root_count = ROOTS_TWO;
      end else begin
        r.root_count = ROOTS_NONE;
      end
    end
    r.overflow = ovf;
    return r;
  endfunction

  // ---------------- driving ----------------
  // drop valid only while idling; a following transaction keeps it high
  task automatic send_coefs(input coef_t c);
    if (tx_idle_enable)
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    roots_expected.push_back(solve_roots(c));
    @(negedge clk);
  endtask

  task automatic send_abc(input int a, input int b, input int c);
    coef_t t;
    t.coef_a = a; t.coef_b = b; t.coef_c = c;
    send_coefs(t);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (roots_expected.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_zero_tolerance <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tol_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random coefficient: full range, small values, near-zero values, or whole numbers from -32 to 32
  function automatic int rand_coef(input int tol);
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(16'hffff)) - 32768;
      2: return $signed($urandom_range(2 * tol + 4)) - tol - 2;
      default: return ($signed($urandom_range(64)) - 32) <<< FB;
    endcase
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (roots_expected.size() == 0) begin
        $error("unexpected result transaction");
        err_count++;
      end else begin
        result_t e;
        e = roots_expected.pop_front();
        if (out_data.root_count !== e.root_count) begin
          $error("root_count exp %0d got %0d", e.root_count, out_data.root_count);
          err_count++;
        end
        if (out_data.root_low !== e.root_low) begin
          $error("root_low exp %0d got %0d", e.root_low, out_data.root_low);
          err_count++;
        end
        if (out_data.root_high !== e.root_high) begin
          $error("root_high exp %0d got %0d", e.root_high, out_data.root_high);
          err_count++;
        end
        if (out_data.overflow !== e.overflow) begin
          $error("overflow exp %0d got %0d", e.overflow, out_data.overflow);
          err_count++;
        end
      end
    end
  end

  // receiver: random stalls when enabled, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= rx_idle_enable ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_abc(0, 0, 0);
    send_abc(0, 0, 1 <<< FB);
    send_abc(0, 2 <<< FB, -(4 <<< FB));
    send_abc(0, 1, 32'sh7fffffff);
    send_abc(1 <<< FB, -(3 <<< FB), 2 <<< FB);
    send_abc(1 <<< FB, 2 <<< FB, 1 <<< FB);
    send_abc(1 <<< FB, 0, 1 <<< FB);
    send_abc(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_abc(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_abc(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_abc(1, 32'sh7fffffff, 0);
    send_abc(1, 32'sh80000000, 1);
    send_abc(-1, 0, 32'sh7fffffff);
    send_abc(1 <<< FB, 0, -(1 <<< FB));
    send_abc(32'sh7fffffff, 0, 32'sh80000000);
    send_abc(-(2 <<< FB), 1, 3);
  endtask

  task automatic test_tolerance_edges();
    write_tolerance(16'hffff);
    send_abc(16'hffff, 16'hffff, 16'hffff);
    send_abc(32'sh10000, 16'hffff, 5);
    send_abc(-16'shffff, 32'sh10000, -32'sh1000);
    send_abc(1 <<< FB, 0, -1);
    send_abc(1 <<< FB, 32'sh20000, 32'sh10000);
    send_abc(1 <<< FB, 32'sh100, 32'sh10000);
    write_tolerance(16'd1);
    send_abc(1, -1, 1);
    send_abc(1 <<< FB, 2, 1);
    write_tolerance('0);
  endtask

  task automatic test_random(input int n);
    coef_t c;
    for (int i = 0; i < n; i++) begin
      c.coef_a = rand_coef(tol_q);
      c.coef_b = rand_coef(tol_q);
      c.coef_c = rand_coef(tol_q);
      send_coefs(c);
    end
  endtask

  task automatic test_backpressure();
    coef_t c;
    drain_results();
    hold_off_cycles = 400;
    tx_idle_enable = 1'b0;
    for (int i = 0; i < 150; i++) begin
      c.coef_a = $urandom; c.coef_b = $urandom; c.coef_c = $urandom;
      send_coefs(c);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    // no idling stretch first, then random idling on both sides
    test_random(150);
    tx_idle_enable = 1'b1;
    rx_idle_enable = 1'b1;
    test_random(300);
    test_tolerance_edges();
    write_tolerance(16'd37);
    test_random(150);
    write_tolerance(16'd4000);
    test_random(150);
    test_backpressure();
    tx_idle_enable = 1'b1;
    write_tolerance('0);
    test_random(100);
    drain_results();
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
src/qes_pkg.sv
src/qes_sqrt_cell.sv
src/qes_div_cell.sv
src/quadratic_equation_solver.sv
sim/tb_quadratic_equation_solver.sv
